// ===== src/ica_pkg.sv =====
`timescale 1ns / 1ps

package ica_pkg;

   // Operand and result width
   localparam int unsigned DATA_W = 64;
   localparam int unsigned HALF_W = DATA_W / 2;
   localparam int unsigned FUNC_W = 3;

   typedef logic [FUNC_W-1:0]        func_type;
   typedef logic signed [DATA_W-1:0] data_type;

   // Operation codes
   localparam func_type FUNC_ADD = 3'd0;
   localparam func_type FUNC_SUB = 3'd1;
   localparam func_type FUNC_MUL = 3'd2;
   localparam func_type FUNC_DIV = 3'd3;
   localparam func_type FUNC_POW = 3'd4;

endpackage

// ===== src/ica_if.sv =====
`timescale 1ns / 1ps

// Request channel: operation code and two operands per beat
interface ica_req_if;
   logic                 valid;
   logic                 ready;
   ica_pkg::func_type    func;
   ica_pkg::data_type    operand_a;
   ica_pkg::data_type    operand_b;

   modport source (output valid, output func, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input func, input operand_a, input operand_b,
                   output ready);
endinterface

// Response channel: result and divide-by-zero flag per beat
interface ica_rsp_if;
   logic                 valid;
   logic                 ready;
   ica_pkg::data_type    result;
   logic                 div_by_zero;

   modport source (output valid, output result, output div_by_zero, input ready);
   modport sink   (input valid, input result, input div_by_zero, output ready);
endinterface

// ===== src/ica_mul.sv =====
`timescale 1ns / 1ps

// Iterative 64x64 multiplier, low half of the product only.
// One 32x32 multiplier runs three partial products; the product is ready
// (done high for one cycle) once the last partial product is accumulated.
module ica_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ica_pkg::data_type op_a,
   input  ica_pkg::data_type op_b,
   output logic              done,
   output ica_pkg::data_type product
);

   logic                             busy_ff;
   logic                             done_ff;
   logic [1:0]                       step_ff;
   logic [ica_pkg::DATA_W-1:0]       a_ff;
   logic [ica_pkg::DATA_W-1:0]       b_ff;
   logic [ica_pkg::DATA_W-1:0]       part_ff;
   logic [ica_pkg::DATA_W-1:0]       part_in;
   logic [ica_pkg::DATA_W-1:0]       acc_ff;
   logic [ica_pkg::HALF_W-1:0]       mul_x;
   logic [ica_pkg::HALF_W-1:0]       mul_y;
   logic [ica_pkg::HALF_W-1:0]       upper_in;

   // Pick operand halves: lo*lo, lo*hi, hi*lo
   always_comb begin
      mul_x = (step_ff == 2'd2) ? a_ff[ica_pkg::DATA_W-1:ica_pkg::HALF_W]
                                : a_ff[ica_pkg::HALF_W-1:0];
      mul_y = (step_ff == 2'd1) ? b_ff[ica_pkg::DATA_W-1:ica_pkg::HALF_W]
                                : b_ff[ica_pkg::HALF_W-1:0];
      part_in  = mul_x * mul_y;
      upper_in = acc_ff[ica_pkg::DATA_W-1:ica_pkg::HALF_W] +
                 part_ff[ica_pkg::HALF_W-1:0];
   end

   // Sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         done_ff <= busy_ff && (step_ff == 2'd3);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 2'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Latch operands, register each partial product, then accumulate it
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      if (busy_ff) begin
         part_ff <= part_in;
         unique case (step_ff)
            2'd0: acc_ff <= acc_ff;
            2'd1: acc_ff <= part_ff;
            2'd2, 2'd3: acc_ff[ica_pkg::DATA_W-1:ica_pkg::HALF_W] <= upper_in;
            default: acc_ff <= acc_ff;
         endcase
      end
   end

   assign done    = done_ff;
   assign product = ica_pkg::data_type'(acc_ff);

endmodule

// ===== src/integer_calculator_alu.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Beat contents                       Handshake
// req_ch   in   func, operand_a, operand_b          valid/ready
// rsp_ch   out  result, div_by_zero                 valid/ready
//
// One request at a time; req_ch.ready is high only while the sequencer idles.
// Add, subtract, unused codes, a zero divisor and a negative exponent go straight
// to FINISH; multiply waits on the shared 32x32 unit; divide runs a restoring
// step for each quotient bit, then a sign fix; power multiplies for each set
// exponent bit and squares for each bit under the top set bit. A finished result waits in FINISH until the
// output register frees; a stalled response holds its beat. Reset is synchronous.
module integer_calculator_alu (
   input  logic          clock,
   input  logic          reset,
   ica_req_if.sink       req_ch,
   ica_rsp_if.source     rsp_ch
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_MUL     = 3'd1;
   localparam logic [2:0] ST_DIV     = 3'd2;
   localparam logic [2:0] ST_DIV_FIX = 3'd3;
   localparam logic [2:0] ST_POW     = 3'd4;
   localparam logic [2:0] ST_POW_ACC = 3'd5;
   localparam logic [2:0] ST_POW_SQ  = 3'd6;
   localparam logic [2:0] ST_FINISH  = 3'd7;

   localparam int unsigned W = ica_pkg::DATA_W;
   localparam int unsigned CNT_W = $clog2(W);

   logic [2:0]        state_ff;
   logic [2:0]        state_in;
   logic              accept;
   logic              out_free;

   logic [W-1:0]      res_ff;
   logic              dz_ff;
   logic [W-1:0]      acc_ff;
   logic [W-1:0]      sq_ff;
   logic [W-1:0]      exp_ff;
   logic [W-1:0]      rem_ff;
   logic [W-1:0]      quo_ff;
   logic [W-1:0]      dvs_ff;
   logic              neg_ff;
   logic [CNT_W-1:0]  cnt_ff;

   logic              out_valid_ff;
   logic [W-1:0]      out_result_ff;
   logic              out_dz_ff;

   logic              mul_start;
   logic              mul_done;
   ica_pkg::data_type mul_a;
   ica_pkg::data_type mul_b;
   ica_pkg::data_type mul_p;

   logic [W-1:0]      in_a;
   logic [W-1:0]      in_b;
   logic [W-1:0]      mag_a;
   logic [W-1:0]      mag_b;
   logic [W:0]        trial;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign in_a     = req_ch.operand_a;
   assign in_b     = req_ch.operand_b;
   assign mag_a    = in_a[W-1] ? (~in_a + 1'b1) : in_a;
   assign mag_b    = in_b[W-1] ? (~in_b + 1'b1) : in_b;
   assign trial    = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};

   ica_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   // Issue multiplies and choose their operands
   always_comb begin
      mul_start = 1'b0;
      mul_a     = ica_pkg::data_type'(sq_ff);
      mul_b     = ica_pkg::data_type'(sq_ff);
      priority if (state_ff == ST_IDLE) begin
         mul_start = accept && (req_ch.func == ica_pkg::FUNC_MUL);
         mul_a     = req_ch.operand_a;
         mul_b     = req_ch.operand_b;
      end else if (state_ff == ST_POW) begin
         mul_start = (exp_ff != '0);
         if (exp_ff[0]) begin
            mul_a = ica_pkg::data_type'(acc_ff);
         end
      end else if (state_ff == ST_POW_ACC) begin
         mul_start = mul_done && (exp_ff[W-1:1] != '0);
      end else begin
         mul_start = 1'b0;
      end
   end

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_ch.func)
                  ica_pkg::FUNC_MUL: state_in = ST_MUL;
                  ica_pkg::FUNC_DIV: state_in = (in_b == '0) ? ST_FINISH : ST_DIV;
                  ica_pkg::FUNC_POW: state_in = in_b[W-1] ? ST_FINISH : ST_POW;
                  default:           state_in = ST_FINISH;
               endcase
            end
         end
         ST_MUL:     if (mul_done) state_in = ST_FINISH;
         ST_DIV:     if (cnt_ff == CNT_W'(W - 1)) state_in = ST_DIV_FIX;
         ST_DIV_FIX: state_in = ST_FINISH;
         ST_POW: begin
            priority if (exp_ff == '0) begin
               state_in = ST_FINISH;
            end else if (exp_ff[0]) begin
               state_in = ST_POW_ACC;
            end else begin
               state_in = ST_POW_SQ;
            end
         end
         ST_POW_ACC: if (mul_done) state_in = (exp_ff[W-1:1] != '0) ? ST_POW_SQ : ST_POW;
         ST_POW_SQ:  if (mul_done) state_in = ST_POW;
         ST_FINISH:  if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FINISH && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            acc_ff <= W'(1);
            sq_ff  <= in_a;
            exp_ff <= in_b;
            rem_ff <= '0;
            quo_ff <= mag_a;
            dvs_ff <= mag_b;
            neg_ff <= in_a[W-1] ^ in_b[W-1];
            cnt_ff <= '0;
            unique case (req_ch.func)
               ica_pkg::FUNC_ADD: begin
                  res_ff <= in_a + in_b;
                  dz_ff  <= 1'b0;
               end
               ica_pkg::FUNC_SUB: begin
                  res_ff <= in_a - in_b;
                  dz_ff  <= 1'b0;
               end
               ica_pkg::FUNC_DIV: begin
                  res_ff <= '0;
                  dz_ff  <= (in_b == '0);
               end
               ica_pkg::FUNC_POW: begin
                  res_ff <= in_a;
                  dz_ff  <= 1'b0;
               end
               default: begin
                  res_ff <= '0;
                  dz_ff  <= 1'b0;
               end
            endcase
         end
         ST_MUL: if (mul_done) res_ff <= mul_p;
         ST_DIV: begin
            // Restoring step: keep the difference when it does not go negative
            rem_ff <= trial[W] ? {rem_ff[W-2:0], quo_ff[W-1]} : trial[W-1:0];
            quo_ff <= {quo_ff[W-2:0], ~trial[W]};
            cnt_ff <= cnt_ff + 1'b1;
         end
         ST_DIV_FIX: res_ff <= neg_ff ? (~quo_ff + 1'b1) : quo_ff;
         ST_POW: if (exp_ff == '0) res_ff <= acc_ff;
         ST_POW_ACC: begin
            if (mul_done) begin
               acc_ff <= mul_p;
               if (exp_ff[W-1:1] == '0) begin
                  exp_ff <= '0;
               end
            end
         end
         ST_POW_SQ: begin
            if (mul_done) begin
               sq_ff  <= mul_p;
               exp_ff <= {1'b0, exp_ff[W-1:1]};
            end
         end
         ST_FINISH: begin
            // Hold results until the output register frees
         end
         default: begin
         end
      endcase
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && out_free) begin
         out_result_ff <= res_ff;
         out_dz_ff     <= dz_ff;
      end
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.result      = ica_pkg::data_type'(out_result_ff);
   assign rsp_ch.div_by_zero = out_dz_ff;

`ifndef SYNTHESIS
   // Divide by zero always carries a zero result
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.div_by_zero |-> rsp_ch.result == '0)
      else $error("div_by_zero with nonzero result");

   // Multiplier finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL || state_ff == ST_POW_ACC || state_ff == ST_POW_SQ))
      else $error("multiplier done outside a multiply state");

   // A response beat leaves only when taken
   assert property (@(posedge clock) disable iff (reset)
      $fell(out_valid_ff) |-> $past(rsp_ch.ready))
      else $error("response dropped without ready");

   // An accepted request always moves the sequencer out of idle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("sequencer did not leave idle after a request");
`endif

endmodule

// ===== tb/sv/integer_calculator_alu_tb.sv =====
`timescale 1ns / 1ps

module integer_calculator_alu_tb;

   localparam ica_pkg::data_type DATA_MIN =
      ica_pkg::data_type'({1'b1, {(ica_pkg::DATA_W-1){1'b0}}});
   localparam ica_pkg::data_type DATA_MAX = ~DATA_MIN;
   localparam int unsigned FUNC_CODES = 2 ** ica_pkg::FUNC_W;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct {
      ica_pkg::data_type result;
      logic              div_by_zero;
   } alu_result_type;

   // Receiver stall modes
   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_LONG_HOLD} rx_mode_type;

   logic clock;
   logic reset;

   ica_req_if req_bus ();
   ica_rsp_if rsp_bus ();

   integer_calculator_alu dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus.sink),
      .rsp_ch (rsp_bus.source)
   );

   alu_result_type pending_results[$];
   int unsigned mismatch_count = 0;
   int unsigned burst_left = 0;

   // Arithmetic of one request, wrapped to 64 bits
   function automatic alu_result_type compute_alu_result(ica_pkg::func_type f,
                                                         ica_pkg::data_type a,
                                                         ica_pkg::data_type b);
      alu_result_type r;
      logic [ica_pkg::DATA_W-1:0] ua;
      logic [ica_pkg::DATA_W-1:0] ub;
      logic [ica_pkg::DATA_W-1:0] mag_a;
      logic [ica_pkg::DATA_W-1:0] mag_b;
      logic [ica_pkg::DATA_W-1:0] quo;
      logic [ica_pkg::DATA_W-1:0] acc;
      logic [ica_pkg::DATA_W-1:0] sq;
      logic [ica_pkg::DATA_W-1:0] e;
      ua = a;
      ub = b;
      r.result = '0;
      r.div_by_zero = 1'b0;
      case (f)
         ica_pkg::FUNC_ADD: r.result = ua + ub;
         ica_pkg::FUNC_SUB: r.result = ua - ub;
         ica_pkg::FUNC_MUL: r.result = ua * ub;
         ica_pkg::FUNC_DIV: begin
            if (ub == '0) begin
               r.div_by_zero = 1'b1;
            end else begin
               mag_a = ua[ica_pkg::DATA_W-1] ? ('0 - ua) : ua;
               mag_b = ub[ica_pkg::DATA_W-1] ? ('0 - ub) : ub;
               quo = mag_a / mag_b;
               r.result = (ua[ica_pkg::DATA_W-1] ^ ub[ica_pkg::DATA_W-1]) ? ('0 - quo) : quo;
            end
         end
         ica_pkg::FUNC_POW: begin
            if (ub[ica_pkg::DATA_W-1]) begin
               // negative exponent leaves the base as it is
               r.result = ua;
            end else begin
               acc = ica_pkg::DATA_W'(1);
               sq = ua;
               e = ub;
               while (e != '0) begin
                  if (e[0])
                     acc = acc * sq;
                  sq = sq * sq;
                  e = e >> 1;
               end
               r.result = acc;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard limit on run time
   initial begin
      #(64'd100_000_000);
      $display("Mismatches found");
      $finish;
   end

   // Response ready: switch between randomly chosen stall modes
   initial begin
      rx_mode_type rx_mode;
      int unsigned mode_left;
      int unsigned hold_left;
      rx_mode = RX_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         case (rx_mode)
            RX_ALWAYS: rsp_bus.ready = 1'b1;
            RX_COIN:   rsp_bus.ready = 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_bus.ready = (mode_left % 4 == 0);
            default: begin
               if (hold_left != 0) begin
                  rsp_bus.ready = 1'b0;
                  hold_left--;
               end else begin
                  rsp_bus.ready = 1'b1;
                  hold_left = $urandom_range(5, 40);
               end
            end
         endcase
      end
   end

   // Compare each response beat with the oldest expected result
   always @(posedge clock) begin
      alu_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected response: result %0d div_by_zero %0b",
                        rsp_bus.result, rsp_bus.div_by_zero);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.result !== want.result || rsp_bus.div_by_zero !== want.div_by_zero) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("response mismatch: result %0d (want %0d) div_by_zero %0b (want %0b)",
                           rsp_bus.result, want.result, rsp_bus.div_by_zero,
                           want.div_by_zero);
            end
         end
      end
   end

   // Send one request beat; may idle between bursts, hold valid within a burst
   task automatic send_request(input ica_pkg::func_type f, input ica_pkg::data_type a,
                               input ica_pkg::data_type b);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.func = f;
      req_bus.operand_a = a;
      req_bus.operand_b = b;
      do
         @(posedge clock);
      while (!req_bus.ready);
      pending_results.push_back(compute_alu_result(f, a, b));
   endtask

   // Drop valid and wait until every expected response has come back
   task automatic drain_responses();
      @(negedge clock);
      req_bus.valid = 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Operand mix: full random, small, extremes, single bits, shrunk random
   function automatic ica_pkg::data_type random_operand();
      ica_pkg::data_type v;
      case ($urandom_range(0, 7))
         0, 1, 2: v = {$urandom, $urandom};
         3: v = ica_pkg::data_type'($urandom_range(0, 64)) - 32;
         4: begin
            case ($urandom_range(0, 4))
               0: v = DATA_MIN;
               1: v = DATA_MAX;
               2: v = '0;
               3: v = 1;
               default: v = -1;
            endcase
         end
         5: begin
            v = ica_pkg::data_type'(1) <<< $urandom_range(0, ica_pkg::DATA_W - 1);
            if ($urandom_range(0, 1))
               v = -v;
         end
         default: v = ica_pkg::data_type'({$urandom, $urandom}) >>>
                      $urandom_range(1, ica_pkg::DATA_W - 1);
      endcase
      return v;
   endfunction

   task automatic test_add_sub_mul_extremes();
      send_request(ica_pkg::FUNC_ADD, DATA_MAX, 1);
      send_request(ica_pkg::FUNC_ADD, DATA_MIN, -1);
      send_request(ica_pkg::FUNC_SUB, DATA_MIN, 1);
      send_request(ica_pkg::FUNC_SUB, '0, DATA_MIN);
      send_request(ica_pkg::FUNC_MUL, DATA_MIN, -1);
      send_request(ica_pkg::FUNC_MUL, DATA_MAX, DATA_MAX);
   endtask

   task automatic test_divide_special();
      send_request(ica_pkg::FUNC_DIV, DATA_MAX, '0);
      send_request(ica_pkg::FUNC_DIV, DATA_MIN, -1);
      send_request(ica_pkg::FUNC_DIV, -7, 2);
      send_request(ica_pkg::FUNC_DIV, 7, -2);
      send_request(ica_pkg::FUNC_DIV, DATA_MIN, DATA_MAX);
   endtask

   task automatic test_power_special();
      send_request(ica_pkg::FUNC_POW, DATA_MIN, '0);
      send_request(ica_pkg::FUNC_POW, -5, 1);
      send_request(ica_pkg::FUNC_POW, 3, -2);
      send_request(ica_pkg::FUNC_POW, 2, 63);
      send_request(ica_pkg::FUNC_POW, -1, DATA_MAX);
      send_request(ica_pkg::FUNC_POW, 3, 40);
   endtask

   task automatic test_unused_codes();
      for (int unsigned c = ica_pkg::FUNC_POW + 1; c < FUNC_CODES; c++)
         send_request(ica_pkg::func_type'(c), DATA_MAX, DATA_MIN);
   endtask

   task automatic test_random_mix(input int unsigned count);
      ica_pkg::func_type f;
      ica_pkg::data_type a;
      ica_pkg::data_type b;
      repeat (count) begin
         a = random_operand();
         b = random_operand();
         if ($urandom_range(0, 15) == 0)
            f = ica_pkg::func_type'($urandom_range(ica_pkg::FUNC_POW + 1, FUNC_CODES - 1));
         else
            f = ica_pkg::func_type'($urandom_range(ica_pkg::FUNC_ADD, ica_pkg::FUNC_POW));
         case (f)
            ica_pkg::FUNC_DIV: begin
               case ($urandom_range(0, 19))
                  0, 1: b = '0;
                  2: begin
                     a = DATA_MIN;
                     b = -1;
                  end
                  default: ;
               endcase
            end
            ica_pkg::FUNC_POW: begin
               // keep exponents short most of the time, the block is slow on long ones
               case ($urandom_range(0, 19))
                  0, 1, 2: b = ica_pkg::data_type'({1'b1, 31'($urandom), $urandom});
                  3: b = ica_pkg::data_type'({1'b0, 31'($urandom), $urandom});
                  default: b = $urandom_range(0, 24);
               endcase
            end
            default: ;
         endcase
         send_request(f, a, b);
      end
   endtask

   // Stimulus
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func = ica_pkg::FUNC_ADD;
      req_bus.operand_a = '0;
      req_bus.operand_b = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_add_sub_mul_extremes();
      test_divide_special();
      test_power_special();
      test_unused_codes();
      test_random_mix(500);
      // pause until the block has returned everything, then go on
      drain_responses();
      test_random_mix(500);
      drain_responses();

      repeat (50) @(posedge clock);
      if (pending_results.size() != 0)
         mismatch_count++;
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
